FILE: hw/rtl/itoa_pkg.sv
// Shared format codes, character constants and helpers of the integer to ASCII formatter.
package itoa_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_HEX = 2'd1;
  localparam logic [1:0] OP_BIN = 2'd2;
  localparam logic [1:0] OP_BAD = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + wide;
    end
    return CH_UPA + wide - 8'd10;
  endfunction

endpackage

FILE: hw/rtl/itoa_front.sv
// Front end: accepts items, drops unknown formats, masks the value and queues jobs.
module itoa_front #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             operation_i,
  input  logic [31:0]            value_i,
  output logic                   job_valid_o,
  input  logic                   job_take_i,
  output logic [1:0]             job_op_o,
  output logic [VALUE_WIDTH-1:0] job_value_o
);
  import itoa_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]             op_mem    [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   accept, enq, deq;

  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign accept      = push && !full;
  assign enq         = accept && (operation_i != OP_BAD);
  assign job_valid_o = (count_q != '0);
  assign deq         = job_take_i && job_valid_o;
  assign job_op_o    = op_mem[rptr_q];
  assign job_value_o = value_mem[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (enq) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (deq) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (enq && !deq) begin
      count_d = count_q + CNT_W'(1);
    end else if (deq && !enq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      op_mem[wptr_q]    <= operation_i;
      value_mem[wptr_q] <= value_i[VALUE_WIDTH-1:0];
    end
  end

endmodule

FILE: hw/rtl/itoa_back.sv
// Back end: binary to BCD conversion, leading zero skip and character sequencing.
module itoa_back #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_take_o,
  input  logic [1:0]             job_op_i,
  input  logic [VALUE_WIDTH-1:0] job_value_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             character_o,
  output logic                   last_o
);
  import itoa_pkg::*;

  localparam int unsigned NIB   = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned PW    = 4 * NIB;
  localparam int unsigned DD    = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned SW    = 4 * DD;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned ND_W  = $clog2(DD + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_PRE0 = 3'd3;
  localparam logic [2:0] S_PREX = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_BSP  = 3'd6;
  localparam logic [2:0] S_BBIT = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [1:0]             op_q, op_d;
  logic [SW-1:0]          sr_q, sr_d, adj;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [ND_W-1:0]        ndig_q, ndig_d;
  logic [1:0]             bc_q, bc_d;
  logic [7:0]             char_q, ch;
  logic                   last_q, lst;
  logic                   valid_q;
  logic                   adv, emit;
  logic [3:0]             top;

  assign adv         = !valid_q || pop;
  assign top         = sr_q[SW-1 -: 4];
  assign empty       = !valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  always_comb begin
    for (int i = 0; i < DD; i++) begin
      adj[4*i +: 4] = (sr_q[4*i +: 4] >= 4'd5) ? sr_q[4*i +: 4] + 4'd3 : sr_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    sr_d       = sr_q;
    bin_d      = bin_q;
    cnt_d      = cnt_q;
    ndig_d     = ndig_q;
    bc_d       = bc_q;
    job_take_o = 1'b0;
    emit       = 1'b0;
    ch         = CH_ZERO;
    lst        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          op_d       = job_op_i;
          if (job_op_i == OP_DEC) begin
            sr_d    = '0;
            bin_d   = job_value_i;
            cnt_d   = CNT_W'(VALUE_WIDTH);
            state_d = S_CONV;
          end else begin
            sr_d    = SW'(job_value_i) << (SW - PW);
            ndig_d  = ND_W'(NIB);
            state_d = S_SKIP;
          end
        end
      end
      S_CONV: begin
        sr_d  = {adj[SW-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = bin_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          ndig_d  = ND_W'(DD);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (ndig_q > ND_W'(1) && top == 4'd0) begin
          sr_d   = sr_q << 4;
          ndig_d = ndig_q - ND_W'(1);
        end else begin
          state_d = (op_q == OP_DEC) ? S_EMIT : S_PRE0;
        end
      end
      S_PRE0: begin
        if (adv) begin
          emit    = 1'b1;
          ch      = CH_ZERO;
          state_d = S_PREX;
        end
      end
      S_PREX: begin
        if (adv) begin
          emit    = 1'b1;
          ch      = (op_q == OP_HEX) ? CH_X : CH_B;
          state_d = (op_q == OP_BIN && top != 4'd0) ? S_BSP : S_EMIT;
        end
      end
      S_EMIT: begin
        if (adv) begin
          emit   = 1'b1;
          ch     = nibble_char(top);
          lst    = (ndig_q == ND_W'(1));
          sr_d   = sr_q << 4;
          ndig_d = ndig_q - ND_W'(1);
          if (ndig_q == ND_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_BSP: begin
        if (adv) begin
          emit    = 1'b1;
          ch      = CH_SPACE;
          bc_d    = 2'd0;
          state_d = S_BBIT;
        end
      end
      S_BBIT: begin
        if (adv) begin
          emit = 1'b1;
          ch   = sr_q[SW-1] ? CH_ONE : CH_ZERO;
          sr_d = sr_q << 1;
          bc_d = bc_q + 2'd1;
          if (bc_q == 2'd3) begin
            ndig_d  = ndig_q - ND_W'(1);
            lst     = (ndig_q == ND_W'(1));
            state_d = (ndig_q == ND_W'(1)) ? S_IDLE : S_BSP;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sr_q   <= sr_d;
    bin_q  <= bin_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    bc_q   <= bc_d;
    if (emit) begin
      char_q <= ch;
      last_q <= lst;
    end
  end

endmodule

FILE: hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: front end, job queue and back end.
//
// Each transfer on the input side carries a format (decimal, hex with 0x, binary with 0b
// and a space before every nibble group) and a value whose low VALUE_WIDTH bits are
// formatted; an unknown format is accepted and produces nothing. Characters leave one per
// transfer on the result side with last set on the final one. A two-entry job queue sits
// between the front end and the back end, so up to two items are taken while a number is
// still being written out. Per item the back end loads the job, then for decimal runs
// shift-and-add-3 conversion over all VALUE_WIDTH bits, then drops leading zero digits
// and leaves the skip, then writes out the characters; hex and binary skip the conversion.
// A single conversion and sequencing unit handles the jobs in turn, with a one-character
// output register.
module integer_to_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  character_o,
  output logic        last_o
);
  import itoa_pkg::*;

  logic                   job_valid;
  logic                   job_take;
  logic [1:0]             job_op;
  logic [VALUE_WIDTH-1:0] job_value;

  itoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .value_i     (value_i),
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_op_o    (job_op),
    .job_value_o (job_value)
  );

  itoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_op_i    (job_op),
    .job_value_i (job_value),
    .empty       (empty),
    .pop         (pop),
    .character_o (character_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  a_take_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> job_valid)
    else $error("back end took a job from an empty queue");

  a_full_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> job_valid)
    else $error("queue reports full without a waiting job");

  a_no_double_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |=> !job_take)
    else $error("back end took jobs on consecutive cycles");

  a_known_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> (job_op == OP_DEC || job_op == OP_HEX || job_op == OP_BIN))
    else $error("unknown format reached the job queue head");
`endif

endmodule

FILE: verif/integer_to_ascii_formatter_tb.sv
// Self-checking testbench for the integer to ASCII formatter: directed table, then random traffic.
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned MAX_GAP      = 8;
  localparam int unsigned RECV_HOLD    = 400;
  localparam int unsigned BURST_ITEMS  = 12;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam string       HEX_DIGITS   = "0123456789ABCDEF";
  localparam logic [31:0] POW10 [10]   = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
                                           32'd100000, 32'd1000000, 32'd10000000,
                                           32'd100000000, 32'd1000000000};

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } ascii_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] value;
    bit          typed;
    string       text;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic [1:0]  operation_i = OP_DEC;
  logic [31:0] value_i     = '0;
  logic        pop         = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  character_o;
  logic        last_o;

  ascii_t      expected_chars[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches   = 0;
  int unsigned send_calm    = 0;
  int unsigned recv_calm    = 0;
  bit          hold_pending = 1'b0;

  always #5 clk_i = ~clk_i;

  integer_to_ascii_formatter #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .operation_i(operation_i),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .character_o(character_o),
    .last_o     (last_o)
  );

  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void add_char(input logic [7:0] c);
    expected_chars.push_back('{character: c, last: 1'b0});
  endfunction

  function automatic int unsigned significant_bits(input logic [31:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic void predict_run(input logic [1:0] op, input logic [31:0] raw);
    logic [31:0] v;
    logic [31:0] rest;
    logic [3:0]  dec_digits[$];
    int          nibs;
    if (op == OP_BAD) begin
      return;
    end
    v = raw;
    if (VALUE_WIDTH < 32) begin
      v = raw & ((32'd1 << VALUE_WIDTH) - 32'd1);
    end
    nibs = int'((significant_bits(v) + 3) / 4);
    case (op)
      OP_DEC: begin
        rest = v;
        do begin
          dec_digits.push_front(4'(rest % 32'd10));
          rest = rest / 32'd10;
        end while (rest != 0);
        foreach (dec_digits[i]) begin
          add_char(CH_ZERO + 8'(dec_digits[i]));
        end
      end
      OP_HEX: begin
        add_char(CH_ZERO);
        add_char(CH_X);
        if (nibs == 0) begin
          add_char(CH_ZERO);
        end
        for (int i = nibs - 1; i >= 0; i--) begin
          add_char(HEX_DIGITS[int'(v[i*4 +: 4])]);
        end
      end
      default: begin
        add_char(CH_ZERO);
        add_char(CH_B);
        if (nibs == 0) begin
          add_char(CH_ZERO);
        end
        for (int i = nibs * 4 - 1; i >= 0; i--) begin
          if (i % 4 == 3) begin
            add_char(CH_SPACE);
          end
          add_char(v[i] ? CH_ONE : CH_ZERO);
        end
      end
    endcase
    expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic void expect_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      expected_chars.push_back('{character: text[i], last: (i == text.len() - 1)});
    end
  endfunction

  function automatic void check_char(input logic [7:0] got_char, input logic got_last);
    ascii_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: unexpected character %h last %b", $realtime, got_char, got_last);
      end
      return;
    end
    want = expected_chars.pop_front();
    if (got_char !== want.character || got_last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: mismatch: character expected %h got %h, last expected %b got %b",
                 $realtime, want.character, got_char, want.last, got_last);
      end
    end
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [31:0] value,
                                  input bit typed, input string text);
    directed_rows.push_back('{op: op, value: value, typed: typed, text: text});
  endfunction

  function automatic logic [1:0] random_op();
    if ($urandom_range(0, 15) == 0) begin
      return OP_BAD;
    end
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [31:0] random_value();
    int unsigned k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0:       return $urandom() >> k;
      1:       return 32'd1 << k;
      2:       return 32'hFFFF_FFFF >> k;
      3:       return POW10[$urandom_range(0, 9)] + 32'($urandom_range(0, 2)) - 32'd1;
      4:       return 32'($urandom_range(0, 20));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] value,
                           input bit typed, input string text, input bit eager);
    int unsigned gap;
    gap = eager ? 0 : draw_gap(send_calm);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    operation_i <= op;
    value_i     <= value;
    do @(posedge clk_i); while (full !== 1'b0);
    if (typed) begin
      expect_text(text);
    end else begin
      predict_run(op, value);
    end
  endtask

  task automatic drain_pause();
    push <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned runs;
    bit          hold_done;
    bit          drain_done;
    logic [1:0]  op;
    add_row(OP_DEC, 32'd0,          1'b1, "0");
    add_row(OP_HEX, 32'd0,          1'b1, "0x0");
    add_row(OP_BIN, 32'd0,          1'b1, "0b0");
    add_row(OP_DEC, 32'd1,          1'b1, "1");
    add_row(OP_DEC, 32'd9,          1'b1, "9");
    add_row(OP_DEC, 32'd10,         1'b1, "10");
    add_row(OP_DEC, 32'd999999999,  1'b1, "999999999");
    add_row(OP_DEC, 32'hFFFF_FFFF,  1'b1, "4294967295");
    add_row(OP_DEC, 32'h8000_0000,  1'b1, "2147483648");
    add_row(OP_HEX, 32'hFFFF_FFFF,  1'b1, "0xFFFFFFFF");
    add_row(OP_HEX, 32'h8000_0000,  1'b1, "0x80000000");
    add_row(OP_HEX, 32'hA,          1'b1, "0xA");
    add_row(OP_HEX, 32'h10,         1'b1, "0x10");
    add_row(OP_BIN, 32'd1,          1'b1, "0b 0001");
    add_row(OP_BIN, 32'hA3,         1'b1, "0b 1010 0011");
    add_row(OP_BIN, 32'hFFFF_FFFF,  1'b1, "0b 1111 1111 1111 1111 1111 1111 1111 1111");
    add_row(OP_BAD, 32'd0,          1'b1, "");
    add_row(OP_BAD, 32'hFFFF_FFFF,  1'b1, "");
    add_row(OP_BIN, 32'h8000_0000,  1'b0, "");
    add_row(OP_DEC, 32'd1000000000, 1'b0, "");
    add_row(OP_HEX, 32'h1234_ABCD,  1'b0, "");
    add_row(OP_BIN, 32'h5A5A_0F0F,  1'b0, "");
    add_row(OP_DEC, 32'h7FFF_FFFF,  1'b0, "");
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].text, 1'b0);
    end
    drain_pause();
    runs       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (runs < RANDOM_ITEMS) begin
      if (!hold_done && runs >= RANDOM_ITEMS / 3) begin
        hold_done    = 1'b1;
        hold_pending = 1'b1;
        repeat (BURST_ITEMS) begin
          send_item(random_op(), random_value(), 1'b0, "", 1'b1);
        end
      end
      if (!drain_done && runs >= 2 * RANDOM_ITEMS / 3) begin
        drain_done = 1'b1;
        drain_pause();
      end
      op = random_op();
      send_item(op, random_value(), 1'b0, "", 1'b0);
      if (op != OP_BAD) begin
        runs++;
      end
    end
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        repeat (RECV_HOLD) @(posedge clk_i);
      end else begin
        gap = draw_gap(recv_calm);
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      check_char(character_o, last_o);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: integer_to_ascii_formatter.f
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_front.sv
hw/rtl/itoa_back.sv
hw/rtl/integer_to_ascii_formatter.sv
verif/integer_to_ascii_formatter_tb.sv
